[rtl/ftdt_pkg.sv]
// shared types and constants for the float to decimal text converter
package ftdt_pkg;

    // single-precision field layout
    localparam int          MANT_W          = 24;
    localparam int          EXP_SHIFT_BIAS  = 150;
    localparam logic [7:0]  EXP_ALL_ONES    = 8'hFF;

    // ascii codes used in the text
    localparam logic [7:0]  ASCII_ZERO      = 8'h30;
    localparam logic [7:0]  ASCII_NINE      = 8'h39;
    localparam logic [7:0]  ASCII_DOT       = 8'h2E;
    localparam logic [7:0]  ASCII_MINUS     = 8'h2D;
    localparam logic [7:0]  ERR_CHAR        = 8'h00;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DABBLE,
        ST_SIGN,
        ST_SKIP,
        ST_INT,
        ST_DOT,
        ST_FRAC
    } state_t;

    // what the next output beat carries
    typedef enum logic [2:0] {
        CHAR_ERR,
        CHAR_MINUS,
        CHAR_INT,
        CHAR_DOT,
        CHAR_FRAC
    } char_kind_t;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       dabble;
        logic       int_shift;
        logic       frac_step;
        logic       emit;
        char_kind_t kind;
        logic       last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic err;
        logic over;
        logic neg;
        logic dabble_last;
        logic int_top_zero;
        logic int_last;
        logic frac_last;
        logic out_free;
    } stat_t;

endpackage

[rtl/float_to_decimal_text.sv]
// top level: single-precision float to fixed-point decimal ascii text
//
// Each input beat is a raw IEEE single-precision bit pattern; the block answers with
// its decimal text, one ascii character per output beat, m_tlast on the final one:
// an optional '-', the integer part without leading zeros, '.', and FRACTION_DIGITS
// fraction digits truncated toward zero. Conversion is exact fixed-point arithmetic.
// A magnitude of 10^INTEGER_DIGITS or more, an infinity or a NaN gives a single beat
// with m_tuser set, m_tdata zero and m_tlast set. One value is converted at a time:
// the accept cycle decodes, a check state range checks, then a bit-serial
// double-dabble loop runs over the bits of the integer part, a sign state follows
// (taken whether or not a '-' goes out), a skip state drops the leading zeros, and
// the integer digits, the point and the fraction digits go out in turn. An error
// value ends after the range check. Output stalls hold the sequence. The next
// value is accepted as soon as the last character sits in the output register.
module float_to_decimal_text #(
    parameter int FRACTION_DIGITS = 6,
    parameter int INTEGER_DIGITS  = 7
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] float_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] text_char
    output logic        m_tlast,
    output logic        m_tuser    // [0] status
);

    ftdt_pkg::cmd_t  cmd;
    ftdt_pkg::stat_t stat;

    // sequencing
    ftdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // arithmetic and output register
    ftdt_datapath #(
        .FRACTION_DIGITS (FRACTION_DIGITS),
        .INTEGER_DIGITS  (INTEGER_DIGITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

[rtl/ftdt_datapath.sv]
// datapath: float decode, fixed-point word, double dabble, digit generation, output register
module ftdt_datapath #(
    parameter int FRACTION_DIGITS = 6,
    parameter int INTEGER_DIGITS  = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [31:0]      s_tdata,
    input  ftdt_pkg::cmd_t   cmd,
    output ftdt_pkg::stat_t  stat,
    input  logic             m_tready,
    output logic             m_tvalid,
    output logic [7:0]       m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    localparam logic [63:0] ILIMIT = 64'd10 ** INTEGER_DIGITS;
    localparam int IW  = $clog2(ILIMIT);
    localparam int K   = ftdt_pkg::MANT_W + 4 * FRACTION_DIGITS;
    localparam int WW  = IW + K;
    localparam int BW  = 4 * INTEGER_DIGITS;
    localparam int CW  = $clog2(IW + 1);
    localparam int IDW = $clog2(INTEGER_DIGITS + 1);
    localparam int FDW = $clog2(FRACTION_DIGITS + 1);

    logic [7:0]            exp_f;
    logic [7:0]            exp_eff;
    logic [23:0]           mant;
    logic [9:0]            exp_sum;
    logic [9:0]            shamt;
    logic [WW-1:0]         word;
    logic                  too_big;
    logic                  neg;
    logic [BW-1:0]         bcd_adj;
    logic [BW+IW-1:0]      dabble_word;
    logic [K+3:0]          fr10;
    logic [7:0]            char;

    logic                  err_reg,   err_next;
    logic                  neg_reg,   neg_next;
    logic [IW-1:0]         ibin_reg,  ibin_next;
    logic [BW-1:0]         bcd_reg,   bcd_next;
    logic [K-1:0]          fr_reg,    fr_next;
    logic [CW-1:0]         dcnt_reg,  dcnt_next;
    logic [IDW-1:0]        icnt_reg,  icnt_next;
    logic [FDW-1:0]        fcnt_reg,  fcnt_next;
    logic                  mvalid_reg, mvalid_next;
    logic [7:0]            mdata_reg,  mdata_next;
    logic                  mlast_reg,  mlast_next;
    logic                  muser_reg,  muser_next;

    // decode the float into a fixed-point word with K fraction bits
    always_comb begin
        exp_f   = s_tdata[30:23];
        exp_eff = (exp_f == 8'd0) ? 8'd1 : exp_f;
        mant    = {exp_f != 8'd0, s_tdata[22:0]};
        exp_sum = 10'(exp_eff) + 10'(K);
        shamt   = exp_sum - 10'(ftdt_pkg::EXP_SHIFT_BIAS);
        if (exp_sum < 10'(ftdt_pkg::EXP_SHIFT_BIAS)) begin
            word = '0;
        end else begin
            word = WW'(mant) << shamt;
        end
        too_big = (exp_f == ftdt_pkg::EXP_ALL_ONES) ||
                  (9'(exp_eff) > 9'(IW + ftdt_pkg::EXP_SHIFT_BIAS - ftdt_pkg::MANT_W));
        neg     = s_tdata[31] && (s_tdata[30:0] != 31'd0);
    end

    // double dabble correction on every digit, then shift the whole word left
    always_comb begin
        for (int d = 0; d < INTEGER_DIGITS; d++) begin
            if (bcd_reg[4*d +: 4] >= 4'd5) begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            end else begin
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
            end
        end
        dabble_word = {bcd_adj, ibin_reg} << 1;
    end

    // fraction times ten: the next digit lands above the binary point
    assign fr10 = ({4'd0, fr_reg} << 3) + ({4'd0, fr_reg} << 1);

    // character select
    always_comb begin
        case (cmd.kind)
            ftdt_pkg::CHAR_ERR:   char = ftdt_pkg::ERR_CHAR;
            ftdt_pkg::CHAR_MINUS: char = ftdt_pkg::ASCII_MINUS;
            ftdt_pkg::CHAR_INT:   char = ftdt_pkg::ASCII_ZERO + {4'd0, bcd_reg[BW-1 -: 4]};
            ftdt_pkg::CHAR_DOT:   char = ftdt_pkg::ASCII_DOT;
            ftdt_pkg::CHAR_FRAC:  char = ftdt_pkg::ASCII_ZERO + {4'd0, fr10[K+3:K]};
            default:              char = ftdt_pkg::ERR_CHAR;
        endcase
    end

    // next values of the working registers
    always_comb begin
        err_next  = err_reg;
        neg_next  = neg_reg;
        ibin_next = ibin_reg;
        bcd_next  = bcd_reg;
        fr_next   = fr_reg;
        dcnt_next = dcnt_reg;
        icnt_next = icnt_reg;
        fcnt_next = fcnt_reg;
        if (cmd.load) begin
            err_next  = too_big;
            neg_next  = neg;
            ibin_next = word[WW-1:K];
            fr_next   = word[K-1:0];
            bcd_next  = '0;
            dcnt_next = '0;
            icnt_next = '0;
            fcnt_next = '0;
        end
        if (cmd.dabble) begin
            bcd_next  = dabble_word[BW+IW-1:IW];
            ibin_next = dabble_word[IW-1:0];
            dcnt_next = dcnt_reg + CW'(1);
        end
        if (cmd.int_shift) begin
            bcd_next  = bcd_reg << 4;
            icnt_next = icnt_reg + IDW'(1);
        end
        if (cmd.frac_step) begin
            fr_next   = fr10[K-1:0];
            fcnt_next = fcnt_reg + FDW'(1);
        end
    end

    // output register
    always_comb begin
        mvalid_next = mvalid_reg;
        mdata_next  = mdata_reg;
        mlast_next  = mlast_reg;
        muser_next  = muser_reg;
        if (cmd.emit) begin
            mvalid_next = 1'b1;
            mdata_next  = char;
            mlast_next  = cmd.last;
            muser_next  = (cmd.kind == ftdt_pkg::CHAR_ERR);
        end else if (m_tready) begin
            mvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        err_reg   <= err_next;
        neg_reg   <= neg_next;
        ibin_reg  <= ibin_next;
        bcd_reg   <= bcd_next;
        fr_reg    <= fr_next;
        dcnt_reg  <= dcnt_next;
        icnt_reg  <= icnt_next;
        fcnt_reg  <= fcnt_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mvalid_reg <= 1'b0;
        end else begin
            mvalid_reg <= mvalid_next;
        end
    end

    // status back to the controller
    always_comb begin
        stat.err          = err_reg;
        stat.over         = (ibin_reg >= IW'(ILIMIT));
        stat.neg          = neg_reg;
        stat.dabble_last  = (dcnt_reg == CW'(IW - 1));
        stat.int_top_zero = (bcd_reg[BW-1 -: 4] == 4'd0);
        stat.int_last     = (icnt_reg == IDW'(INTEGER_DIGITS - 1));
        stat.frac_last    = (fcnt_reg == FDW'(FRACTION_DIGITS - 1));
        stat.out_free     = !mvalid_reg || m_tready;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

endmodule

[rtl/ftdt_ctrl.sv]
// controller: sequences decode, conversion and the character beats
module ftdt_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ftdt_pkg::stat_t  stat,
    output ftdt_pkg::cmd_t   cmd
);

    ftdt_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ftdt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.load      = 1'b0;
        cmd.dabble    = 1'b0;
        cmd.int_shift = 1'b0;
        cmd.frac_step = 1'b0;
        cmd.emit      = 1'b0;
        cmd.kind      = ftdt_pkg::CHAR_ERR;
        cmd.last      = 1'b0;
        case (state_reg)
            ftdt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ftdt_pkg::ST_CHECK;
                end
            end
            // out of range, infinity or nan gives one error beat
            ftdt_pkg::ST_CHECK: begin
                if (stat.err || stat.over) begin
                    if (stat.out_free) begin
                        cmd.emit   = 1'b1;
                        cmd.kind   = ftdt_pkg::CHAR_ERR;
                        cmd.last   = 1'b1;
                        state_next = ftdt_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = ftdt_pkg::ST_DABBLE;
                end
            end
            ftdt_pkg::ST_DABBLE: begin
                cmd.dabble = 1'b1;
                if (stat.dabble_last) begin
                    state_next = ftdt_pkg::ST_SIGN;
                end
            end
            ftdt_pkg::ST_SIGN: begin
                if (!stat.neg) begin
                    state_next = ftdt_pkg::ST_SKIP;
                end else if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = ftdt_pkg::CHAR_MINUS;
                    state_next = ftdt_pkg::ST_SKIP;
                end
            end
            // drop leading zeros, keeping the units digit
            ftdt_pkg::ST_SKIP: begin
                if (stat.int_top_zero && !stat.int_last) begin
                    cmd.int_shift = 1'b1;
                end else begin
                    state_next = ftdt_pkg::ST_INT;
                end
            end
            ftdt_pkg::ST_INT: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = ftdt_pkg::CHAR_INT;
                    cmd.int_shift = 1'b1;
                    if (stat.int_last) begin
                        state_next = ftdt_pkg::ST_DOT;
                    end
                end
            end
            ftdt_pkg::ST_DOT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = ftdt_pkg::CHAR_DOT;
                    state_next = ftdt_pkg::ST_FRAC;
                end
            end
            ftdt_pkg::ST_FRAC: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.kind      = ftdt_pkg::CHAR_FRAC;
                    cmd.frac_step = 1'b1;
                    cmd.last      = stat.frac_last;
                    if (stat.frac_last) begin
                        state_next = ftdt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ftdt_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[rtl/ftdt_checker.sv]
// port-level checks for the float to decimal text converter, bound to the top level
module ftdt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // an error beat is a lone zero character that ends the value
    a_err_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == ftdt_pkg::ERR_CHAR))
        else $error("malformed error beat");

    // normal beats carry only sign, point or digit characters
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |->
            (m_tdata == ftdt_pkg::ASCII_MINUS) || (m_tdata == ftdt_pkg::ASCII_DOT) ||
            ((m_tdata >= ftdt_pkg::ASCII_ZERO) && (m_tdata <= ftdt_pkg::ASCII_NINE)))
        else $error("illegal text character");

    // one value at a time: input closes right after a beat is taken
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while converting");

endmodule

bind float_to_decimal_text ftdt_checker u_ftdt_checker (.*);

[verif/float_to_decimal_text_tb.sv]
// self-checking testbench for the float to decimal text converter
`timescale 1ns / 100ps

module float_to_decimal_text_tb;

    localparam int          FRAC_DIGITS  = 6;
    localparam logic [63:0] FRAC_SCALE   = 64'd1000000;
    localparam logic [63:0] INT_LIMIT    = 64'd10000000;
    localparam int          MAX_SHIFT_UP = 40;
    localparam int          RANDOM_FLOATS = 460;
    localparam int          STALL_LIMIT  = 4000;
    localparam int          DRAIN_CYCLES = 64;

    // idle percentages per phase: sender, receiver
    localparam int SEND_IDLE [3] = '{37, 76, 0};
    localparam int RECV_IDLE [3] = '{76, 37, 0};

    // hand-picked values: zeros, subnormals, range edges, non-finite
    localparam logic [31:0] CORNER_FLOATS [22] = '{
        32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h8000_0001,
        32'h007F_FFFF, 32'h0080_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h3DCC_CCCD, 32'h3F7F_FFFF, 32'h33D6_BF95, 32'hB3D6_BF95,
        32'h42F6_E979, 32'h4B00_0000, 32'h4B18_967F, 32'hCB18_967F,
        32'h4B18_9680, 32'h4B7F_FFFF, 32'h7F7F_FFFF, 32'h7F80_0000,
        32'hFF80_0000, 32'hFFFF_FFFF
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } text_beat_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    logic [31:0] float_queue [$];
    text_beat_t  text_expected [$];
    int          floats_total   = 1;
    int          floats_taken   = 0;
    int          mismatch_count = 0;
    int          stall_cycles   = 0;
    bit          in_beat_taken  = 1'b0;

    float_to_decimal_text dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("[%0t] mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last, input logic bad);
        text_beat_t beat;
        beat.ch   = ch;
        beat.last = last;
        beat.bad  = bad;
        text_expected.push_back(beat);
    endtask

    // exact fixed-point conversion of one float to its expected characters
    task automatic predict_text(input logic [31:0] fbits);
        logic        neg;
        logic [7:0]  expf;
        logic [63:0] mant;
        logic [63:0] ipart;
        logic [63:0] scaled;
        logic [63:0] frac;
        int          shift;
        int          down;
        int          nd;
        logic [3:0]  digs [24];

        neg  = fbits[31];
        expf = fbits[30:23];
        mant = {41'd0, fbits[22:0]};

        // infinity and nan
        if (expf == ftdt_pkg::EXP_ALL_ONES) begin
            push_char(ftdt_pkg::ERR_CHAR, 1'b1, 1'b1);
            return;
        end

        // subnormals keep exponent field 1 without the hidden bit
        if (expf == 8'd0) begin
            shift = 1 - ftdt_pkg::EXP_SHIFT_BIAS;
        end else begin
            mant[23] = 1'b1;
            shift = int'(expf) - ftdt_pkg::EXP_SHIFT_BIAS;
        end

        if (shift >= 0) begin
            if (shift > MAX_SHIFT_UP) begin
                push_char(ftdt_pkg::ERR_CHAR, 1'b1, 1'b1);
                return;
            end
            ipart = mant << shift;
        end else begin
            down  = -shift;
            ipart = (down >= 64) ? 64'd0 : (mant >> down);
        end

        // magnitude out of range
        if (ipart >= INT_LIMIT) begin
            push_char(ftdt_pkg::ERR_CHAR, 1'b1, 1'b1);
            return;
        end

        if (shift >= 0)
            scaled = ipart * FRAC_SCALE;
        else
            scaled = (down >= 64) ? 64'd0 : ((mant * FRAC_SCALE) >> down);
        frac = scaled % FRAC_SCALE;

        // minus only for a nonzero magnitude
        if (neg && mant != 64'd0)
            push_char(ftdt_pkg::ASCII_MINUS, 1'b0, 1'b0);

        nd = 0;
        do begin
            digs[nd] = 4'(ipart % 10);
            ipart    = ipart / 10;
            nd++;
        end while (ipart != 64'd0 && nd < 24);
        for (int i = nd - 1; i >= 0; i--)
            push_char(ftdt_pkg::ASCII_ZERO + 8'(digs[i]), 1'b0, 1'b0);

        push_char(ftdt_pkg::ASCII_DOT, 1'b0, 1'b0);

        for (int i = FRAC_DIGITS - 1; i >= 0; i--) begin
            digs[i] = 4'(frac % 10);
            frac    = frac / 10;
        end
        for (int i = 0; i < FRAC_DIGITS; i++)
            push_char(ftdt_pkg::ASCII_ZERO + 8'(digs[i]), i == FRAC_DIGITS - 1, 1'b0);
    endtask

    // random float, weighted toward values that convert to text
    function automatic logic [31:0] random_float();
        int          pick;
        logic [7:0]  expf;
        logic [22:0] mant;

        pick = $urandom_range(99);
        mant = 23'($urandom());
        if (pick < 5)
            mant = (pick < 2) ? '0 : '1;
        if (pick < 12)
            return $urandom();
        else if (pick < 16)
            expf = 8'd0;
        else if (pick < 19)
            expf = ftdt_pkg::EXP_ALL_ONES;
        else if (pick < 32)
            expf = 8'($urandom_range(150, 175));
        else
            expf = 8'($urandom_range(100, 149));
        return {1'($urandom_range(1)), expf, mant};
    endfunction

    // input driver: next float once the previous beat is gone
    always @(negedge aclk) begin
        int phase;
        phase = (floats_taken * 3) / floats_total;
        if (phase > 2)
            phase = 2;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (!s_tvalid || in_beat_taken) begin
                if (float_queue.size() != 0 && $urandom_range(99) >= SEND_IDLE[phase]) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= float_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= RECV_IDLE[phase]);
        end
    end

    // monitor: predict on input beats, check output beats
    always @(posedge aclk) begin
        text_beat_t want;
        bit         out_beat_taken;
        in_beat_taken  = aresetn && s_tvalid && s_tready;
        out_beat_taken = aresetn && m_tvalid && m_tready;
        if (in_beat_taken) begin
            predict_text(s_tdata);
            floats_taken++;
        end
        if (out_beat_taken) begin
            if (text_expected.size() == 0) begin
                report_mismatch("character beat with nothing pending", 64'(m_tdata), 64'd0);
            end else begin
                want = text_expected.pop_front();
                if (m_tdata !== want.ch)
                    report_mismatch("text char", 64'(m_tdata), 64'(want.ch));
                if (m_tlast !== want.last)
                    report_mismatch("last flag", 64'(m_tlast), 64'(want.last));
                if (m_tuser !== want.bad)
                    report_mismatch("error status", 64'(m_tuser), 64'(want.bad));
            end
        end
        // stall watchdog
        if (in_beat_taken || out_beat_taken)
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge aclk);
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus and end of run
    initial begin
        foreach (CORNER_FLOATS[i])
            float_queue.push_back(CORNER_FLOATS[i]);
        for (int i = 0; i < RANDOM_FLOATS; i++)
            float_queue.push_back(random_float());
        floats_total = float_queue.size();

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (float_queue.size() != 0 || s_tvalid || text_expected.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && text_expected.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
